### rtl/core/svg_pkg.sv
// shared widths, register codes, stage plan and types of the sphere vertex generator
package svg_pkg;

  localparam int unsigned RAD_W      = 15;
  localparam int unsigned DIVS_W     = 8;
  localparam int unsigned BANDS_W    = 9;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam int unsigned MAX_BANDS     = 256;
  localparam int unsigned MAX_DIVISIONS = 255;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISIONS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BANDS     = 2'd2;

  localparam logic [RAD_W-1:0]   RADIUS_RST = 15'd2048;
  localparam logic [DIVS_W-1:0]  DIVS_RST   = 8'd64;
  localparam logic [BANDS_W-1:0] BANDS_RST  = 9'd64;

  localparam int unsigned POS_W = 16;
  localparam int unsigned NRM_W = 16;
  localparam int unsigned TEX_W = 17;

  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;
  localparam logic [NRM_W-1:0]        NRM_ONE = 16'd16384;

  // index dividers: height, phase, v coordinate
  localparam int unsigned DV_NW = 25;
  localparam int unsigned DV_TW = DV_NW + 1;
  localparam int unsigned DV_QW = 17;
  localparam int unsigned DV_DW = 9;

  // normal y divider
  localparam int unsigned NY_NW = 30;
  localparam int unsigned NY_TW = NY_NW + 1;
  localparam int unsigned NY_QW = 15;

  // ring radius square root
  localparam int unsigned SQ_W     = 30;
  localparam int unsigned SQ_TW    = SQ_W + 1;
  localparam int unsigned SQ_STEPS = 15;

  // rotation unit
  localparam int unsigned CD_STEPS = 30;
  localparam int unsigned CD_W     = 33;
  localparam int unsigned CS_W     = 32;
  localparam logic signed [CD_W-1:0] CD_GAIN = 33'sd652032874;

  localparam logic [31:0] ATAN_TURNS [CD_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  // products and normal x/z dividers
  localparam int unsigned PR_W  = 49;
  localparam int unsigned NX_NW = 49;
  localparam int unsigned NX_TW = NX_NW + 1;
  localparam int unsigned NX_QW = 16;

  // stage plan
  localparam int unsigned ST_DV     = DV_QW;
  localparam int unsigned ST_SQ     = ST_DV + 1;
  localparam int unsigned ST_DF     = ST_SQ + 1;
  localparam int unsigned ST_RT     = ST_DF + SQ_STEPS + 1;
  localparam int unsigned ST_NYE    = ST_SQ + NY_QW;
  localparam int unsigned ST_CDE    = ST_DV + CD_STEPS;
  localparam int unsigned ST_CS     = ST_CDE + 1;
  localparam int unsigned ST_PR     = ST_CS + 1;
  localparam int unsigned ST_PM     = ST_PR + 1;
  localparam int unsigned ST_NXE    = ST_PM + NX_QW;
  localparam int unsigned LATENCY   = ST_NXE + 1;

  typedef struct packed {
    logic [RAD_W-1:0]   radius;
    logic [DIVS_W-1:0]  divs;
    logic [BANDS_W-1:0] bands_m1;
  } svg_cfg_t;

  typedef struct packed {
    logic              range_error;
    logic [TEX_W-1:0]  tex_v;
    logic [TEX_W-1:0]  tex_u;
    logic [NRM_W-1:0]  norm_z;
    logic [NRM_W-1:0]  norm_y;
    logic [NRM_W-1:0]  norm_x;
    logic [POS_W-1:0]  pos_z;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_x;
  } svg_vtx_t;

endpackage

### rtl/core/svg_core.sv
// vertex datapath: dividers, square root, rotation unit, products and normal dividers
module svg_core import svg_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  svg_cfg_t          cfg_i,
  input  logic [IDX_W-1:0]  band_i,
  input  logic [IDX_W-1:0]  ring_i,
  output svg_vtx_t          vtx_o
);

  localparam logic [1:0] QD_0 = 2'd0;
  localparam logic [1:0] QD_1 = 2'd1;
  localparam logic [1:0] QD_2 = 2'd2;

  function automatic logic signed [POS_W-1:0] pos_round(input logic neg,
                                                        input logic [PR_W-1:0] mag);
    logic [PR_W-1:0] q;
    q = (mag + (PR_W'(1) << 29)) >> 30;
    if (neg) begin
      return (q > PR_W'(32768)) ? POS_MIN : POS_W'(-q);
    end
    return (q > PR_W'(32767)) ? POS_MAX : POS_W'(q);
  endfunction

  // input stage
  logic signed [BANDS_W+1:0] yt;
  logic [BANDS_W:0]          yt_mag;
  logic [DV_NW-1:0]          yn, phn, tvn;
  logic                      err_in;

  always_comb begin
    yt     = $signed({2'b00, cfg_i.bands_m1}) - $signed({2'b00, band_i, 1'b0});
    yt_mag = yt[BANDS_W+1] ? (BANDS_W+1)'(-yt) : yt[BANDS_W:0];
    yn     = DV_NW'(cfg_i.radius) * DV_NW'(yt_mag) + DV_NW'(cfg_i.bands_m1 >> 1);
    phn    = {1'b0, ring_i, 16'h0000} + DV_NW'(cfg_i.divs >> 1);
    tvn    = {1'b0, band_i, 16'h0000} + DV_NW'(cfg_i.bands_m1 >> 1);
    err_in = ({1'b0, band_i} > cfg_i.bands_m1) || (ring_i > cfg_i.divs);
  end

  logic [DV_NW-1:0] dy_rem [DV_QW+1];
  logic [DV_QW-1:0] dy_quo [DV_QW+1];
  logic [DV_NW-1:0] ph_rem [DV_QW+1];
  logic [DV_QW-1:0] ph_quo [DV_QW+1];
  logic [DV_NW-1:0] tv_rem [DV_QW+1];
  logic [DV_QW-1:0] tv_quo [DV_QW+1];

  logic err_q  [ST_NXE+1];
  logic yneg_q [ST_DV+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dy_rem[0] <= yn;
      dy_quo[0] <= '0;
      ph_rem[0] <= phn;
      ph_quo[0] <= '0;
      tv_rem[0] <= tvn;
      tv_quo[0] <= '0;
      err_q[0]  <= err_in;
      yneg_q[0] <= yt[BANDS_W+1];
      for (int k = 1; k <= ST_NXE; k++) begin
        err_q[k] <= err_q[k-1];
      end
      for (int k = 1; k <= ST_DV; k++) begin
        yneg_q[k] <= yneg_q[k-1];
      end
    end
  end

  // restoring dividers by band count minus one and division count
  for (genvar k = 1; k <= DV_QW; k++) begin : g_dv
    localparam int unsigned SH = DV_QW - k;
    logic [DV_TW-1:0] tb, td;
    logic             ge_y, ge_p, ge_t;
    assign tb   = DV_TW'(cfg_i.bands_m1) << SH;
    assign td   = DV_TW'(cfg_i.divs) << SH;
    assign ge_y = {1'b0, dy_rem[k-1]} >= tb;
    assign ge_p = {1'b0, ph_rem[k-1]} >= td;
    assign ge_t = {1'b0, tv_rem[k-1]} >= tb;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dy_rem[k] <= ge_y ? DV_NW'({1'b0, dy_rem[k-1]} - tb) : dy_rem[k-1];
        ph_rem[k] <= ge_p ? DV_NW'({1'b0, ph_rem[k-1]} - td) : ph_rem[k-1];
        tv_rem[k] <= ge_t ? DV_NW'({1'b0, tv_rem[k-1]} - tb) : tv_rem[k-1];
        dy_quo[k] <= dy_quo[k-1] | (ge_y ? (DV_QW'(1) << SH) : '0);
        ph_quo[k] <= ph_quo[k-1] | (ge_p ? (DV_QW'(1) << SH) : '0);
        tv_quo[k] <= tv_quo[k-1] | (ge_t ? (DV_QW'(1) << SH) : '0);
      end
    end
  end

  // height, squares and normal y setup
  logic [RAD_W-1:0]        ymag;
  logic signed [POS_W-1:0] posy_q [ST_SQ:ST_NXE];
  logic [TEX_W-1:0]        texu_q [ST_SQ:ST_NXE];
  logic [TEX_W-1:0]        texv_q [ST_SQ:ST_NXE];
  logic [SQ_W-1:0]         y2_q, r2_q;
  logic [NY_NW-1:0]        ny_rem [NY_QW+1];
  logic [NY_QW-1:0]        ny_quo [NY_QW+1];
  logic [NY_QW-1:0]        nyv_q  [ST_NYE+1:ST_NXE];

  assign ymag = dy_quo[ST_DV][RAD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      posy_q[ST_SQ] <= yneg_q[ST_DV] ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
      texu_q[ST_SQ] <= ph_quo[ST_DV];
      texv_q[ST_SQ] <= tv_quo[ST_DV];
      y2_q          <= SQ_W'(ymag) * SQ_W'(ymag);
      r2_q          <= SQ_W'(cfg_i.radius) * SQ_W'(cfg_i.radius);
      ny_rem[0]     <= NY_NW'({ymag, 14'h0000}) + NY_NW'(cfg_i.radius >> 1);
      ny_quo[0]     <= '0;
      for (int k = ST_SQ + 1; k <= ST_NXE; k++) begin
        posy_q[k] <= posy_q[k-1];
        texu_q[k] <= texu_q[k-1];
        texv_q[k] <= texv_q[k-1];
      end
      nyv_q[ST_NYE+1] <= ny_quo[NY_QW];
      for (int k = ST_NYE + 2; k <= ST_NXE; k++) begin
        nyv_q[k] <= nyv_q[k-1];
      end
    end
  end

  for (genvar k = 1; k <= NY_QW; k++) begin : g_ny
    localparam int unsigned SH = NY_QW - k;
    logic [NY_TW-1:0] t;
    logic             ge;
    assign t  = NY_TW'(cfg_i.radius) << SH;
    assign ge = {1'b0, ny_rem[k-1]} >= t;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ny_rem[k] <= ge ? NY_NW'({1'b0, ny_rem[k-1]} - t) : ny_rem[k-1];
        ny_quo[k] <= ny_quo[k-1] | (ge ? (NY_QW'(1) << SH) : '0);
      end
    end
  end

  // ring radius: digit-by-digit square root with rounding
  logic [SQ_W-1:0]  sq_rem [SQ_STEPS+1];
  logic [SQ_TW-1:0] sq_s   [SQ_STEPS+1];
  logic [RAD_W:0]   rad_q  [ST_RT:ST_CS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_rem[0] <= r2_q - y2_q;
      sq_s[0]   <= '0;
      rad_q[ST_RT] <= sq_s[SQ_STEPS][RAD_W:0]
                    + (({1'b0, sq_rem[SQ_STEPS]} > sq_s[SQ_STEPS]) ? (RAD_W+1)'(1) : '0);
      for (int k = ST_RT + 1; k <= ST_CS; k++) begin
        rad_q[k] <= rad_q[k-1];
      end
    end
  end

  for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sq
    localparam logic [SQ_TW-1:0] BITV = SQ_TW'(1) << (2 * (SQ_STEPS - j));
    logic [SQ_TW-1:0] sum;
    logic             ge;
    assign sum = sq_s[j-1] + BITV;
    assign ge  = {1'b0, sq_rem[j-1]} >= sum;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rem[j] <= ge ? SQ_W'({1'b0, sq_rem[j-1]} - sum) : sq_rem[j-1];
        sq_s[j]   <= ge ? (sq_s[j-1] >> 1) + BITV : (sq_s[j-1] >> 1);
      end
    end
  end

  // rotation unit, one step per stage
  logic signed [CD_W-1:0] cx [CD_STEPS+1];
  logic signed [CD_W-1:0] cy [CD_STEPS+1];
  logic signed [CD_W-1:0] cz [CD_STEPS+1];

  assign cx[0] = CD_GAIN;
  assign cy[0] = '0;
  assign cz[0] = $signed({3'b000, ph_quo[ST_DV][13:0], 16'h0000});

  for (genvar k = 1; k <= CD_STEPS; k++) begin : g_cd
    localparam int unsigned SH = k - 1;
    logic signed [CD_W-1:0] xs, ys, at;
    assign xs = cx[k-1] >>> SH;
    assign ys = cy[k-1] >>> SH;
    assign at = $signed({1'b0, ATAN_TURNS[SH]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cz[k-1][CD_W-1]) begin
          cx[k] <= cx[k-1] - ys;
          cy[k] <= cy[k-1] + xs;
          cz[k] <= cz[k-1] - at;
        end else begin
          cx[k] <= cx[k-1] + ys;
          cy[k] <= cy[k-1] - xs;
          cz[k] <= cz[k-1] + at;
        end
      end
    end
  end

  // quadrant, products, position rounding
  logic signed [CS_W-1:0] cos_q, sin_q;
  logic signed [PR_W-1:0] px_q, pz_q;
  logic [PR_W-1:0]        pxm, pzm;
  logic signed [POS_W-1:0] posx_q [ST_PM:ST_NXE];
  logic signed [POS_W-1:0] posz_q [ST_PM:ST_NXE];
  logic                    negx_q [ST_PM:ST_NXE];
  logic                    negz_q [ST_PM:ST_NXE];
  logic [NX_NW-1:0]        nx_rem [NX_QW+1];
  logic [NX_QW-1:0]        nx_quo [NX_QW+1];
  logic [NX_NW-1:0]        nz_rem [NX_QW+1];
  logic [NX_QW-1:0]        nz_quo [NX_QW+1];

  assign pxm = px_q[PR_W-1] ? PR_W'(-px_q) : PR_W'(px_q);
  assign pzm = pz_q[PR_W-1] ? PR_W'(-pz_q) : PR_W'(pz_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (texu_q[ST_CDE][15:14])
        QD_0: begin
          cos_q <= CS_W'(cx[CD_STEPS]);
          sin_q <= CS_W'(cy[CD_STEPS]);
        end
        QD_1: begin
          cos_q <= CS_W'(-cy[CD_STEPS]);
          sin_q <= CS_W'(cx[CD_STEPS]);
        end
        QD_2: begin
          cos_q <= CS_W'(-cx[CD_STEPS]);
          sin_q <= CS_W'(-cy[CD_STEPS]);
        end
        default: begin
          cos_q <= CS_W'(cy[CD_STEPS]);
          sin_q <= CS_W'(-cx[CD_STEPS]);
        end
      endcase
      px_q <= PR_W'($signed({1'b0, rad_q[ST_CS]})) * PR_W'(cos_q);
      pz_q <= PR_W'($signed({1'b0, rad_q[ST_CS]})) * PR_W'(sin_q);
      posx_q[ST_PM] <= pos_round(px_q[PR_W-1], pxm);
      posz_q[ST_PM] <= pos_round(pz_q[PR_W-1], pzm);
      negx_q[ST_PM] <= px_q[PR_W-1];
      negz_q[ST_PM] <= pz_q[PR_W-1];
      nx_rem[0]     <= pxm + (NX_NW'(cfg_i.radius) << 15);
      nz_rem[0]     <= pzm + (NX_NW'(cfg_i.radius) << 15);
      nx_quo[0]     <= '0;
      nz_quo[0]     <= '0;
      for (int k = ST_PM + 1; k <= ST_NXE; k++) begin
        posx_q[k] <= posx_q[k-1];
        posz_q[k] <= posz_q[k-1];
        negx_q[k] <= negx_q[k-1];
        negz_q[k] <= negz_q[k-1];
      end
    end
  end

  // normal x and z: divide by radius scaled by 2^16, rounded, result in Q1.14
  for (genvar k = 1; k <= NX_QW; k++) begin : g_nx
    localparam int unsigned SH = NX_QW - k + 16;
    logic [NX_TW-1:0] t;
    logic             gx, gz;
    assign t  = NX_TW'(cfg_i.radius) << SH;
    assign gx = {1'b0, nx_rem[k-1]} >= t;
    assign gz = {1'b0, nz_rem[k-1]} >= t;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_rem[k] <= gx ? NX_NW'({1'b0, nx_rem[k-1]} - t) : nx_rem[k-1];
        nz_rem[k] <= gz ? NX_NW'({1'b0, nz_rem[k-1]} - t) : nz_rem[k-1];
        nx_quo[k] <= nx_quo[k-1] | (gx ? (NX_QW'(1) << (SH - 16)) : '0);
        nz_quo[k] <= nz_quo[k-1] | (gz ? (NX_QW'(1) << (SH - 16)) : '0);
      end
    end
  end

  // output register
  logic [NRM_W-1:0] mx, mz, my;
  svg_vtx_t         vtx_d, vtx_q;

  always_comb begin
    mx = (nx_quo[NX_QW] > NRM_ONE) ? NRM_ONE : nx_quo[NX_QW];
    mz = (nz_quo[NX_QW] > NRM_ONE) ? NRM_ONE : nz_quo[NX_QW];
    my = NRM_W'(nyv_q[ST_NXE]);
    vtx_d = '0;
    vtx_d.range_error = err_q[ST_NXE];
    if (!err_q[ST_NXE]) begin
      vtx_d.pos_x  = posx_q[ST_NXE];
      vtx_d.pos_y  = posy_q[ST_NXE];
      vtx_d.pos_z  = posz_q[ST_NXE];
      vtx_d.norm_x = negx_q[ST_NXE] ? NRM_W'(-mx) : mx;
      vtx_d.norm_y = posy_q[ST_NXE][POS_W-1] ? NRM_W'(-my) : my;
      vtx_d.norm_z = negz_q[ST_NXE] ? NRM_W'(-mz) : mz;
      vtx_d.tex_u  = texu_q[ST_NXE];
      vtx_d.tex_v  = texv_q[ST_NXE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vtx_q <= vtx_d;
    end
  end

  assign vtx_o = vtx_q;

endmodule

### rtl/core/sphere_vertex_generator.sv
// sphere vertex generator top level: stream ports, configuration registers, pipeline control
//
// Slave stream: tdata carries band_index (bits 7:0) and ring_index (bits 15:8).
// Master stream: tdata carries position, normal and texture coordinates of one
// vertex; tuser is set when an index lies outside the configured counts, and
// the tdata of such a transaction is all zeros.
// Configuration channel: index 0 sphere radius, 1 divisions, 2 band count;
// cfg_ready_o is always high and writes to other indexes are dropped. Write
// only while no transaction is in flight.
// Throughput: one transaction per cycle except while the master side stalls,
// set by a pipeline of one quotient bit, one root digit or one rotation step
// per stage.
// Every transaction on the slave side gives exactly one on the master side.
// When the master side stalls with a result waiting, the whole pipeline holds
// and s_axis_tready_o drops; bubbles still move up while the output is empty.
// Reset clears all valid bits and loads radius 2048, 64 divisions, 64 bands.
module sphere_vertex_generator import svg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [15:0]           s_axis_tdata_i,   // band_index, ring_index
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, zero pad
  output logic [135:0]          m_axis_tdata_o,
  output logic                  m_axis_tuser_o,   // range_error
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [RAD_W-1:0]   radius_q;
  logic [DIVS_W-1:0]  divs_q;
  logic [BANDS_W-1:0] bands_q;
  logic [LATENCY:0]   vld_q;
  logic               en;
  svg_cfg_t           cfg;
  svg_vtx_t           vtx;
  logic [DIVS_W-1:0]  divs_c;
  logic [BANDS_W-1:0] bands_c;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      divs_q   <= DIVS_RST;
      bands_q  <= BANDS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RADIUS:    radius_q <= cfg_data_i[RAD_W-1:0];
        CFG_DIVISIONS: divs_q   <= cfg_data_i[DIVS_W-1:0];
        CFG_BANDS:     bands_q  <= cfg_data_i[BANDS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp counts and radius
  always_comb begin
    if (divs_q < DIVS_W'(3)) begin
      divs_c = DIVS_W'(3);
    end else if (divs_q > DIVS_W'(MAX_DIVISIONS)) begin
      divs_c = DIVS_W'(MAX_DIVISIONS);
    end else begin
      divs_c = divs_q;
    end
    if (bands_q < BANDS_W'(3)) begin
      bands_c = BANDS_W'(3);
    end else if (bands_q > BANDS_W'(MAX_BANDS)) begin
      bands_c = BANDS_W'(MAX_BANDS);
    end else begin
      bands_c = bands_q;
    end
    cfg.radius   = (radius_q == '0) ? RAD_W'(1) : radius_q;
    cfg.divs     = divs_c;
    cfg.bands_m1 = bands_c - BANDS_W'(1);
  end

  assign en              = !vld_q[LATENCY] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LATENCY-1:0], s_axis_tvalid_i};
    end
  end

  svg_core u_core (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg),
    .band_i (s_axis_tdata_i[7:0]),
    .ring_i (s_axis_tdata_i[15:8]),
    .vtx_o  (vtx)
  );

  assign m_axis_tvalid_o = vld_q[LATENCY];
  assign m_axis_tuser_o  = vtx.range_error;
  assign m_axis_tdata_o  = {6'b000000, vtx.tex_v, vtx.tex_u, vtx.norm_z, vtx.norm_y,
                            vtx.norm_x, vtx.pos_z, vtx.pos_y, vtx.pos_x};

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted transaction not in first stage");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("range error result carries data");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");
`endif

endmodule
